// ----- design/assert_macros.svh -----
// Assertion macros shared by the resource timeline scheduler modules.
// Each use relies on clk and rst_n being in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define RTS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define RTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/rts_pkg.sv -----
// Types and constants for the resource timeline scheduler.
// No dependencies; used by rts_store and resource_timeline_scheduler.
package rts_pkg;

  localparam int MAX_RESULTS = 40;
  localparam int DUR_W       = 18;
  localparam int MASK_W      = 16;
  localparam int CNT_W       = 6;

  typedef enum logic [2:0] {
    OP_ISSUE    = 3'd0,
    OP_NOP      = 3'd1,
    OP_WAIT_RES = 3'd2,
    OP_WAIT_ALL = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIVE_CHK,
    S_ISSUE_MAX,
    S_REL,
    S_FREE,
    S_INS_SCAN,
    S_INS_REL,
    S_RES_WR,
    S_MAXF1,
    S_MAXF2,
    S_NOP_ADD,
    S_NOP_MAXF,
    S_WAIT_RES,
    S_WAIT_ALL,
    S_D_HEAD,
    S_D_CLIP,
    S_D_DUR,
    S_D_SCAN,
    S_D_POP,
    S_FIN
  } state_t;

  // Commands to the sorted change store.
  typedef struct packed {
    logic clr;
    logic pop;
    logic ins;
  } st_cmd_t;

endpackage

// ----- design/rts_store.sv -----
// Sorted, duplicate-free store of change times kept as a shift line.
// Depends on rts_pkg (st_cmd_t) and assert_macros.svh.
`include "assert_macros.svh"

module rts_store import rts_pkg::*; #(
  parameter int SLOTS = 32,
  parameter int TB    = 40,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  st_cmd_t       cmd,
  input  logic [SW-1:0] ins_pos,
  input  logic [TB-1:0] ins_val,
  input  logic [SW-1:0] rd_idx,
  output logic [TB-1:0] rd_data,
  output logic [TB-1:0] head0,
  output logic [TB-1:0] head1,
  output logic [SW:0]   count
);

  logic [TB-1:0] ct_r [SLOTS];
  logic [SW:0]   count_r;

  assign rd_data = ct_r[rd_idx];
  assign head0   = ct_r[0];
  assign head1   = ct_r[1];
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.pop) begin
      count_r <= count_r - 1'b1;
    end else if (cmd.ins) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (cmd.pop && !cmd.clr) begin
        if (k < SLOTS - 1) begin
          ct_r[k] <= ct_r[(k < SLOTS - 1) ? k + 1 : k];
        end
      end else if (cmd.ins && !cmd.clr) begin
        if (SW'(k) == ins_pos) begin
          ct_r[k] <= ins_val;
        end else if (k > 0 && SW'(k) > ins_pos) begin
          ct_r[k] <= ct_r[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  `RTS_ASSERT(a_cnt_bound, count_r <= (SW+1)'(SLOTS), "change store count beyond depth")
  `RTS_ASSERT_IMPL(a_pop_nonempty, cmd.pop, count_r != '0, "pop on empty change store")
  `RTS_ASSERT_IMPL(a_ins_room, cmd.ins, count_r < (SW+1)'(SLOTS), "insert into full store")

endmodule

// ----- design/resource_timeline_scheduler.sv -----
// Resource timeline scheduler: sequencer, shared add/compare unit, resource table.
// Depends on rts_pkg, rts_store and assert_macros.svh.
`include "assert_macros.svh"

// One operation per input transaction; the block is busy until every segment
// it causes has been handed to the output register. Each change-time
// insertion scans the sorted store from the first slot up to its insert
// position, and each segment waits out any output stalls; the resource
// table is swept one entry per cycle to build the active mask. Clear, a
// zero no-op and an unknown code are ready again on the next cycle. All
// time sums and the sequencer's time compares run through one shared
// TIME_BITS-wide adder and comparator; only the mask sweep keeps its own
// compares. No clearing pass: the block is ready right after reset.
module resource_timeline_scheduler import rts_pkg::*; #(
  parameter int RESOURCES    = 16,
  parameter int CHANGE_SLOTS = 32,
  parameter int TIME_BITS    = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target[3:0], delay[19:4], hold[35:20], cooldown[51:36], clear_first[52]
  input  logic [55:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // duration[17:0], active_mask[33:18]
  output logic [39:0] out_tdata,
  // event_overflow[0]
  output logic [0:0]  out_tuser,
  output logic        out_tlast
);

  localparam int TB = TIME_BITS;
  localparam int SW = $clog2(CHANGE_SLOTS);
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [2:0]    op;
  logic [RW-1:0] rid_tab [16];
  logic [RW-1:0] rid_r, rid_nxt;
  logic [15:0]   delay_r, delay_nxt, hold_r, hold_nxt, cool_r, cool_nxt;
  logic [TB-1:0] issue_r, issue_nxt, sent_r, sent_nxt, maxf_r, maxf_nxt;
  logic [TB-1:0] rel_r, rel_nxt, frt_r, frt_nxt, ins_val_r, ins_val_nxt;
  logic [TB-1:0] next_r, next_nxt, dur_r, dur_nxt;
  logic [SW:0]   pos_r, pos_nxt;
  logic [RW-1:0] ridx_r, ridx_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [DUR_W-1:0]  pend_dur_r, pend_dur_nxt;
  logic [MASK_W-1:0] pend_mask_r, pend_mask_nxt;
  logic          pend_ovf_r, pend_ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DUR_W-1:0]  out_dur_r, out_dur_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic          out_ovf_r, out_ovf_nxt, out_last_r, out_last_nxt;

  logic          live_r [RESOURCES];
  logic [TB-1:0] busy_t_r [RESOURCES];
  logic [TB-1:0] rel_t_r  [RESOURCES];
  logic [TB-1:0] free_t_r [RESOURCES];
  logic [RW-1:0] rd_idx;
  logic [TB-1:0] busy_rd, rel_rd, free_rd;
  logic          live_rd;

  st_cmd_t       st_cmd;
  logic [TB-1:0] st_rd, st_head0, st_head1;
  logic [SW:0]   st_count;

  logic [TB-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub, alu_lt, alu_eq;

  logic accept, do_clr, out_free, emit_stall, cnt_full, st_empty, st_full;
  logic ins_in_range, ins_more, ins_dup, dur_zero, scan_last, hit, retire;
  logic [DUR_W-1:0] dur_sat;

  // target index folded into range, worked out at elaboration
  for (genvar g = 0; g < 16; g++) begin : g_rid
    assign rid_tab[g] = RW'(g % RESOURCES);
  end

  rts_store #(.SLOTS(CHANGE_SLOTS), .TB(TB), .SW(SW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (st_cmd),
    .ins_pos (pos_r[SW-1:0]),
    .ins_val (ins_val_r),
    .rd_idx  (pos_r[SW-1:0]),
    .rd_data (st_rd),
    .head0   (st_head0),
    .head1   (st_head1),
    .count   (st_count)
  );

  assign op        = in_tuser;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign do_clr    = accept && ((op == OP_CLEAR) || (in_tdata[52] &&
                     ((op == OP_ISSUE) || (op == OP_WAIT_RES) || (op == OP_WAIT_ALL) ||
                      ((op == OP_NOP) && (in_tdata[19:4] != '0)))));

  assign out_free   = !out_valid_r || out_tready;
  assign emit_stall = pend_valid_r && !out_free;
  assign cnt_full   = (cnt_r >= CNT_W'(MAX_RESULTS));
  assign st_empty   = (st_count == '0);
  assign st_full    = (st_count == (SW+1)'(CHANGE_SLOTS));

  assign rd_idx  = (state_r == S_D_SCAN) ? ridx_r : rid_r;
  assign live_rd = live_r[rd_idx];
  assign busy_rd = busy_t_r[rd_idx];
  assign rel_rd  = rel_t_r[rd_idx];
  assign free_rd = free_t_r[rd_idx];

  // shared add/subtract and compare unit
  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + TB'(alu_sub);
  assign alu_lt  = (alu_a < alu_b);
  assign alu_eq  = (alu_a == alu_b);

  assign ins_in_range = (pos_r < st_count);
  assign ins_more     = ins_in_range && alu_lt;
  assign ins_dup      = ins_in_range && alu_eq;
  assign dur_zero     = (alu_sum == '0);
  assign scan_last    = (ridx_r == RW'(RESOURCES - 1));
  assign hit          = live_rd && (busy_rd <= sent_r) && (sent_r < rel_rd);
  assign retire       = live_rd && (sent_r >= free_rd);
  assign dur_sat      = (|dur_r[TB-1:DUR_W]) ? '1 : dur_r[DUR_W-1:0];

  always_comb begin
    alu_a   = issue_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_ISSUE_MAX: begin alu_a = issue_r;  alu_b = free_rd; end
      S_REL:       begin alu_a = issue_r;  alu_b = TB'(hold_r); end
      S_FREE:      begin alu_a = rel_r;    alu_b = TB'(cool_r); end
      S_INS_SCAN:  begin alu_a = st_rd;    alu_b = ins_val_r; end
      S_RES_WR:    begin alu_a = issue_r;  alu_b = TB'(delay_r); end
      S_MAXF1:     begin alu_a = maxf_r;   alu_b = frt_r; end
      S_MAXF2:     begin alu_a = maxf_r;   alu_b = issue_r; end
      S_NOP_ADD:   begin alu_a = issue_r;  alu_b = TB'(delay_r); end
      S_NOP_MAXF:  begin alu_a = maxf_r;   alu_b = issue_r; end
      S_WAIT_RES:  begin alu_a = sent_r;   alu_b = free_rd; end
      S_WAIT_ALL:  begin alu_a = issue_r;  alu_b = maxf_r; end
      S_D_HEAD:    begin alu_a = sent_r;   alu_b = st_head0; end
      S_D_CLIP:    begin alu_a = issue_r;  alu_b = next_r; end
      S_D_DUR:     begin alu_a = next_r;   alu_b = sent_r; alu_sub = 1'b1; end
      S_D_POP:     begin alu_a = st_head0; alu_b = next_r; end
      default:     begin alu_a = issue_r;  alu_b = '0; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ISSUE:    state_nxt = S_LIVE_CHK;
            OP_NOP:      state_nxt = (in_tdata[19:4] == '0) ? S_IDLE : S_NOP_ADD;
            OP_WAIT_RES: state_nxt = in_tdata[52] ? S_IDLE : S_WAIT_RES;
            OP_WAIT_ALL: state_nxt = in_tdata[52] ? S_IDLE : S_WAIT_ALL;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_LIVE_CHK:  state_nxt = live_rd ? S_ISSUE_MAX : S_REL;
      S_ISSUE_MAX: state_nxt = S_D_HEAD;
      S_REL:       state_nxt = S_FREE;
      S_FREE:      state_nxt = S_INS_SCAN;
      S_INS_SCAN:  state_nxt = ins_more ? S_INS_SCAN : ret_r;
      S_INS_REL:   state_nxt = S_INS_SCAN;
      S_RES_WR:    state_nxt = S_MAXF1;
      S_MAXF1:     state_nxt = S_MAXF2;
      S_MAXF2:     state_nxt = S_D_HEAD;
      S_NOP_ADD:   state_nxt = S_INS_SCAN;
      S_NOP_MAXF:  state_nxt = S_D_HEAD;
      S_WAIT_RES:  state_nxt = S_D_HEAD;
      S_WAIT_ALL:  state_nxt = S_D_HEAD;
      S_D_HEAD:    state_nxt = (cnt_full || st_empty) ? ret_r : S_D_CLIP;
      S_D_CLIP:    state_nxt = S_D_DUR;
      S_D_DUR:     state_nxt = dur_zero ? ret_r : S_D_SCAN;
      S_D_SCAN:    state_nxt = scan_last ? S_D_POP : S_D_SCAN;
      S_D_POP:     state_nxt = emit_stall ? S_D_POP : S_D_HEAD;
      S_FIN:       state_nxt = emit_stall ? S_FIN : S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_nxt        = ret_r;
    rid_nxt        = rid_r;
    delay_nxt      = delay_r;
    hold_nxt       = hold_r;
    cool_nxt       = cool_r;
    issue_nxt      = issue_r;
    sent_nxt       = sent_r;
    maxf_nxt       = maxf_r;
    rel_nxt        = rel_r;
    frt_nxt        = frt_r;
    ins_val_nxt    = ins_val_r;
    next_nxt       = next_r;
    dur_nxt        = dur_r;
    pos_nxt        = pos_r;
    ridx_nxt       = ridx_r;
    mask_nxt       = mask_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    pend_valid_nxt = pend_valid_r;
    pend_dur_nxt   = pend_dur_r;
    pend_mask_nxt  = pend_mask_r;
    pend_ovf_nxt   = pend_ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_dur_nxt    = out_dur_r;
    out_mask_nxt   = out_mask_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    st_cmd         = '0;
    st_cmd.clr     = do_clr;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rid_nxt   = rid_tab[in_tdata[3:0]];
          delay_nxt = in_tdata[19:4];
          hold_nxt  = in_tdata[35:20];
          cool_nxt  = in_tdata[51:36];
          cnt_nxt   = '0;
          if (do_clr) begin
            issue_nxt = '0;
            sent_nxt  = '0;
            maxf_nxt  = '0;
          end
        end
      end
      S_ISSUE_MAX: begin
        if (alu_lt) issue_nxt = free_rd;
        ret_nxt = S_REL;
      end
      S_REL:  rel_nxt = alu_sum;
      S_FREE: begin
        frt_nxt     = alu_sum;
        ins_val_nxt = issue_r;
        pos_nxt     = '0;
        ret_nxt     = S_INS_REL;
      end
      S_INS_SCAN: begin
        if (ins_more) begin
          pos_nxt = pos_r + 1'b1;
        end else if (!ins_dup) begin
          if (st_full) ovf_nxt = 1'b1;
          else st_cmd.ins = 1'b1;
        end
      end
      S_INS_REL: begin
        ins_val_nxt = rel_r;
        pos_nxt     = '0;
        ret_nxt     = S_RES_WR;
      end
      S_RES_WR: issue_nxt = alu_sum;
      S_MAXF1:  if (alu_lt) maxf_nxt = frt_r;
      S_MAXF2: begin
        if (alu_lt) maxf_nxt = issue_r;
        ret_nxt = S_FIN;
      end
      S_NOP_ADD: begin
        issue_nxt   = alu_sum;
        ins_val_nxt = alu_sum;
        pos_nxt     = '0;
        ret_nxt     = S_NOP_MAXF;
      end
      S_NOP_MAXF: begin
        if (alu_lt) maxf_nxt = issue_r;
        ret_nxt = S_FIN;
      end
      S_WAIT_RES: begin
        if (live_rd && alu_lt) issue_nxt = free_rd;
        ret_nxt = S_FIN;
      end
      S_WAIT_ALL: begin
        if (alu_lt) issue_nxt = maxf_r;
        else maxf_nxt = issue_r;
        ret_nxt = S_FIN;
      end
      S_D_HEAD: begin
        if (!cnt_full && st_empty) begin
          sent_nxt = issue_r;
        end
        if (alu_lt) next_nxt = st_head0;
        else if (st_count > (SW+1)'(1)) next_nxt = st_head1;
        else next_nxt = issue_r;
      end
      S_D_CLIP: if (alu_lt) next_nxt = issue_r;
      S_D_DUR: begin
        dur_nxt  = alu_sum;
        mask_nxt = '0;
        ridx_nxt = '0;
      end
      S_D_SCAN: begin
        if (hit) mask_nxt = mask_r | (MASK_W'(1) << ridx_r);
        if (!scan_last) ridx_nxt = ridx_r + 1'b1;
      end
      S_D_POP: begin
        if (!emit_stall) begin
          sent_nxt   = next_r;
          st_cmd.pop = alu_lt;
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_dur_nxt   = pend_dur_r;
            out_mask_nxt  = pend_mask_r;
            out_ovf_nxt   = pend_ovf_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_dur_nxt   = dur_sat;
          pend_mask_nxt  = mask_r;
          pend_ovf_nxt   = ovf_r;
          cnt_nxt        = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!emit_stall && pend_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_dur_nxt    = pend_dur_r;
          out_mask_nxt   = pend_mask_r;
          out_ovf_nxt    = pend_ovf_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      issue_r      <= '0;
      sent_r       <= '0;
      maxf_r       <= '0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      issue_r      <= issue_nxt;
      sent_r       <= sent_nxt;
      maxf_r       <= maxf_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rid_r       <= rid_nxt;
    delay_r     <= delay_nxt;
    hold_r      <= hold_nxt;
    cool_r      <= cool_nxt;
    rel_r       <= rel_nxt;
    frt_r       <= frt_nxt;
    ins_val_r   <= ins_val_nxt;
    next_r      <= next_nxt;
    dur_r       <= dur_nxt;
    pos_r       <= pos_nxt;
    ridx_r      <= ridx_nxt;
    mask_r      <= mask_nxt;
    pend_dur_r  <= pend_dur_nxt;
    pend_mask_r <= pend_mask_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
    out_dur_r   <= out_dur_nxt;
    out_mask_r  <= out_mask_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  // live bits: cleared by clear, set on issue, dropped once past the free time
  always_ff @(posedge clk) begin
    for (int k = 0; k < RESOURCES; k++) begin
      if (!rst_n || do_clr) begin
        live_r[k] <= 1'b0;
      end else if (state_r == S_RES_WR && rid_r == RW'(k)) begin
        live_r[k] <= 1'b1;
      end else if (state_r == S_D_SCAN && ridx_r == RW'(k) && retire) begin
        live_r[k] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES_WR) begin
      busy_t_r[rid_r] <= issue_r;
      rel_t_r[rid_r]  <= rel_r;
      free_t_r[rid_r] <= frt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_mask_r, out_dur_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  `RTS_ASSERT_IMPL(a_idle_no_pend, in_tready, !pend_valid_r, "segment left pending at idle")
  `RTS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_RESULTS), "too many segments for one item")
  `RTS_ASSERT_IMPL(a_ovf_sticky, $past(ovf_r) && $past(rst_n), ovf_r, "overflow flag lost")

endmodule
